// ===== rtl/core/acr_pkg.sv =====
// Shared types and constants for the address range carver.
// Used by acr_ram's instances, acr_csr and address_range_carver; depends on nothing.
package acr_pkg;

   localparam int MAX_RANGES = 16;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int CSR_AW     = 4;

   typedef struct packed {
      logic [15:0] flag;
      logic [31:0] length;
      logic [31:0] start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [31:0] total_size;
      logic [15:0] type_mask;
      logic [15:0] idle_code;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_CLAIM = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_NOFIT = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_TOTAL_SIZE = 2'd0,
      REG_TYPE_MASK  = 2'd1,
      REG_IDLE_CODE  = 2'd2,
      REG_NONE       = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_SEARCH,
      ST_CLAIM,
      ST_HOLE_LO,
      ST_HOLE_HI,
      ST_KEY_RD,
      ST_KEY_LD,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/acr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the range table of address_range_carver.
module acr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/acr_csr.sv =====
// Configuration registers of the address range carver behind an APB-style port.
// Depends on acr_pkg for the register indexes and the cfg_type bundle.
module acr_csr
   import acr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type reg_sel;
   logic    wr_en;

   assign reg_sel    = reg_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TOTAL_SIZE: cfg_in.total_size = csr_pwdata;
            REG_TYPE_MASK:  cfg_in.type_mask  = csr_pwdata[15:0];
            REG_IDLE_CODE:  cfg_in.idle_code  = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TOTAL_SIZE: csr_prdata = cfg_ff.total_size;
         REG_TYPE_MASK:  csr_prdata = {16'd0, cfg_ff.type_mask};
         REG_IDLE_CODE:  csr_prdata = {16'd0, cfg_ff.idle_code};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_size <= 32'd0;
         cfg_ff.type_mask  <= 16'd15;
         cfg_ff.idle_code  <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/address_range_carver.sv =====
// Address range carver: a table of address ranges kept in ascending start order,
// built from acr_pkg, acr_csr and one acr_ram instance holding the table.
// One beat is taken at a time and the block is not ready until its result is formed.
//
// An init beat writes the first entry at once; a read of a valid entry waits for the
// registered RAM read data; a read past the count and a claim rejected for a full or
// empty table go straight to the result. A claim that finds no fit scans every entry.
// An accepted claim walks the table through the single read port of the table RAM:
// it examines entries in order in the search, writes the claim over its host entry,
// appends the low and high holes where they are left, then runs an insertion pass that
// loads each entry as a key and moves earlier entries that start after it up one place,
// and closes with a result state. A finished result waits in an output register, and
// a new request beat is taken while it waits; a result that cannot enter that register
// holds the block until rsp_tready frees it.
module address_range_carver
   import acr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // req_tdata, low bit up: range_start[31:0], range_length[63:32],
   // range_flag[79:64], entry_index[83:80], zero fill[87:84]
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [87:0]       req_tdata,
   // req_tuser: command[1:0]
   input  logic [1:0]        req_tuser,
   // rsp_tdata, low bit up: entry_start[31:0], entry_length[63:32],
   // entry_flag[79:64], entry_count[84:80], zero fill[87:85]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [87:0]       rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]        rsp_tuser,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   acr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Table RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_rdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;

   acr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);

   // Request fields
   cmd_type     in_cmd;
   logic [31:0] in_start;
   logic [31:0] in_length;
   logic [15:0] in_flag;
   logic [3:0]  in_index;

   assign in_cmd    = cmd_type'(req_tuser);
   assign in_start  = req_tdata[31:0];
   assign in_length = req_tdata[63:32];
   assign in_flag   = req_tdata[79:64];
   assign in_index  = req_tdata[83:80];

   // State
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] found_ff, found_in;
   entry_type        key_ff, key_in;
   entry_type        req_ff, req_in;
   logic [32:0]      req_end_ff, req_end_in;
   logic [31:0]      host_start_ff, host_start_in;
   logic [32:0]      host_end_ff, host_end_in;
   status_type       res_status_ff, res_status_in;
   entry_type        res_entry_ff, res_entry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic [4:0]       rsp_count_ff, rsp_count_in;

   logic        accept;
   logic        full;
   logic        idx_ok;
   logic [32:0] scan_end;
   logic        scan_hit;
   logic        scan_last;
   logic        shift_more;
   logic        out_free;
   logic        hole_lo;
   logic        hole_hi;

   assign accept     = req_tvalid & req_tready;
   assign full       = (32'(cnt_ff) + 32'd2) > 32'(MAX_RANGES);
   assign idx_ok     = 32'(in_index) < 32'(cnt_ff);
   // The search compares against the end sum at 33 bits so it never wraps.
   assign scan_end   = {1'b0, ram_rdata.start} + {1'b0, ram_rdata.length};
   assign scan_hit   = ((ram_rdata.flag & cfg.type_mask) == cfg.idle_code)
                     && (ram_rdata.start <= req_ff.start)
                     && (scan_end >= req_end_ff);
   assign scan_last  = (CNT_W'(i_ff + 1'b1) == cnt_ff);
   assign shift_more = (j_ff != '0) && (ram_rdata.start > key_ff.start);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign hole_lo    = req_ff.start > host_start_ff;
   assign hole_hi    = req_end_ff < host_end_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_cmd)
                  CMD_CLAIM: state_in = (full || cnt_ff == '0) ? ST_DONE : ST_SEARCH;
                  CMD_READ:  state_in = idx_ok ? ST_RD_WAIT : ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_WAIT: state_in = ST_DONE;
         ST_SEARCH: begin
            if (scan_hit) begin
               state_in = ST_CLAIM;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLAIM:   state_in = ST_HOLE_LO;
         ST_HOLE_LO: state_in = ST_HOLE_HI;
         ST_HOLE_HI: state_in = ST_KEY_RD;
         ST_KEY_RD:  state_in = (i_ff >= cnt_ff) ? ST_DONE : ST_KEY_LD;
         ST_KEY_LD:  state_in = ST_SHIFT;
         ST_SHIFT:   state_in = shift_more ? ST_SHIFT : ST_KEY_RD;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_tready    = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      cnt_in        = cnt_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      req_in        = req_ff;
      req_end_in    = req_end_ff;
      host_start_in = host_start_ff;
      host_end_in   = host_end_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               req_in.start  = in_start;
               req_in.length = in_length;
               req_in.flag   = in_flag;
               req_end_in    = {1'b0, in_start} + {1'b0, in_length};
               res_status_in = STS_OK;
               res_entry_in  = '0;
               i_in          = '0;
               case (in_cmd)
                  CMD_INIT: begin
                     ram_we           = 1'b1;
                     ram_waddr        = '0;
                     ram_wdata.start  = 32'd0;
                     ram_wdata.length = cfg.total_size;
                     ram_wdata.flag   = cfg.idle_code;
                     cnt_in           = CNT_W'(1);
                  end
                  CMD_CLAIM: begin
                     if (full) begin
                        res_status_in = STS_FULL;
                     end else if (cnt_ff == '0) begin
                        res_status_in = STS_NOFIT;
                     end
                  end
                  CMD_READ: begin
                     ram_raddr = IDX_W'(in_index);
                     if (!idx_ok) begin
                        res_status_in = STS_RANGE;
                     end
                  end
                  default: res_status_in = STS_OK;
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_entry_in = ram_rdata;
         end
         ST_SEARCH: begin
            // The RAM holds entry i this cycle; entry i+1 is fetched behind it.
            ram_raddr = IDX_W'(i_ff + 1'b1);
            if (scan_hit) begin
               found_in      = IDX_W'(i_ff);
               host_start_in = ram_rdata.start;
               host_end_in   = scan_end;
            end else if (scan_last) begin
               res_status_in = STS_NOFIT;
            end else begin
               i_in = CNT_W'(i_ff + 1'b1);
            end
         end
         ST_CLAIM: begin
            ram_we    = 1'b1;
            ram_waddr = found_ff;
            ram_wdata = req_ff;
         end
         ST_HOLE_LO: begin
            if (hole_lo) begin
               ram_we           = 1'b1;
               ram_waddr        = IDX_W'(cnt_ff);
               ram_wdata.start  = host_start_ff;
               ram_wdata.length = req_ff.start - host_start_ff;
               ram_wdata.flag   = cfg.idle_code;
               cnt_in           = CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_HOLE_HI: begin
            if (hole_hi) begin
               ram_we           = 1'b1;
               ram_waddr        = IDX_W'(cnt_ff);
               ram_wdata.start  = req_end_ff[31:0];
               ram_wdata.length = 32'(host_end_ff - req_end_ff);
               ram_wdata.flag   = cfg.idle_code;
               cnt_in           = CNT_W'(cnt_ff + 1'b1);
            end
            i_in = CNT_W'(1);
         end
         ST_KEY_RD: begin
            ram_raddr = IDX_W'(i_ff);
         end
         ST_KEY_LD: begin
            key_in    = ram_rdata;
            j_in      = IDX_W'(i_ff);
            ram_raddr = IDX_W'(i_ff - 1'b1);
         end
         ST_SHIFT: begin
            // Entry j-1 is on the read port; move it up while it starts after the key.
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (shift_more) begin
               ram_wdata = ram_rdata;
               j_in      = j_ff - 1'b1;
               ram_raddr = j_ff - IDX_W'(2);
            end else begin
               ram_wdata = key_ff;
               i_in      = CNT_W'(i_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = 5'(cnt_ff);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & ~rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      found_ff      <= found_in;
      key_ff        <= key_in;
      req_ff        <= req_in;
      req_end_ff    <= req_end_in;
      host_start_ff <= host_start_in;
      host_end_ff   <= host_end_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_count_ff, rsp_entry_ff.flag,
                        rsp_entry_ff.length, rsp_entry_ff.start};

endmodule

// ===== tb/sv/tb_address_range_carver.sv =====
// Self-checking testbench for address_range_carver: request, response and APB register
// traffic, with a scoreboard class that tracks the sorted range table.
// Depends on acr_pkg and the address_range_carver RTL only.
module tb_address_range_carver;
   timeunit 1ns;
   timeprecision 1ps;

   import acr_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] start;
      logic [31:0] length;
      logic [15:0] flag;
      logic [4:0]  count;
   } carver_reply;

   // Tracks the range table and the registers, and queues the reply owed for each
   // accepted request beat.
   class range_table_model;
      entry_type   entries[MAX_RANGES];
      int          used;
      logic [31:0] total_size;
      logic [15:0] type_mask;
      logic [15:0] idle_code;
      carver_reply pending_replies[$];
      int          mismatch_count;

      function new();
         used           = 0;
         total_size     = 32'd0;
         type_mask      = 16'h000F;
         idle_code      = 16'h0000;
         mismatch_count = 0;
      endfunction

      function void write_reg(reg_type r, logic [31:0] v);
         case (r)
            REG_TOTAL_SIZE: total_size = v;
            REG_TYPE_MASK:  type_mask  = v[15:0];
            REG_IDLE_CODE:  idle_code  = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_type r);
         case (r)
            REG_TOTAL_SIZE: return total_size;
            REG_TYPE_MASK:  return {16'h0000, type_mask};
            REG_IDLE_CODE:  return {16'h0000, idle_code};
            default:        return 32'd0;
         endcase
      endfunction

      function bit is_idle(entry_type e);
         return (e.flag & type_mask) == idle_code;
      endfunction

      // Stable insertion sort on start address.
      function void sort_by_start();
         entry_type key;
         int        j;
         for (int i = 1; i < used; i++) begin
            key = entries[i];
            j   = i;
            while (j > 0 && entries[j-1].start > key.start) begin
               entries[j] = entries[j-1];
               j--;
            end
            entries[j] = key;
         end
      endfunction

      function logic [1:0] claim_range(logic [31:0] b, logic [31:0] n, logic [15:0] f);
         logic [32:0] req_end, host_start, host_end, ent_end;
         int          hit;
         if (used + 2 > MAX_RANGES)
            return STS_FULL;
         req_end = {1'b0, b} + {1'b0, n};
         hit     = -1;
         for (int i = 0; i < used; i++) begin
            ent_end = {1'b0, entries[i].start} + {1'b0, entries[i].length};
            if (hit < 0 && is_idle(entries[i]) && entries[i].start <= b
                && ent_end >= req_end)
               hit = i;
         end
         if (hit < 0)
            return STS_NOFIT;
         host_start = {1'b0, entries[hit].start};
         host_end   = host_start + {1'b0, entries[hit].length};
         entries[hit] = '{flag: f, length: n, start: b};
         if ({1'b0, b} > host_start) begin
            entries[used] = '{flag: idle_code, length: b - host_start[31:0],
                              start: host_start[31:0]};
            used++;
         end
         if (req_end < host_end) begin
            entries[used] = '{flag: idle_code, length: host_end[31:0] - req_end[31:0],
                              start: req_end[31:0]};
            used++;
         end
         sort_by_start();
         return STS_OK;
      endfunction

      function void accept_request(cmd_type cmd, logic [31:0] b, logic [31:0] n,
                                   logic [15:0] f, logic [3:0] idx);
         carver_reply r;
         r.status = STS_OK;
         r.start  = 32'd0;
         r.length = 32'd0;
         r.flag   = 16'd0;
         case (cmd)
            CMD_INIT: begin
               entries[0] = '{flag: idle_code, length: total_size, start: 32'd0};
               used       = 1;
            end
            CMD_CLAIM: r.status = claim_range(b, n, f);
            CMD_READ: begin
               if (idx < used) begin
                  r.start  = entries[idx].start;
                  r.length = entries[idx].length;
                  r.flag   = entries[idx].flag;
               end else begin
                  r.status = STS_RANGE;
               end
            end
            default: ;
         endcase
         r.count = used[4:0];
         pending_replies.push_back(r);
      endfunction

      function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      endfunction

      function void check_response(logic [1:0] sts, logic [87:0] data);
         carver_reply want;
         if (pending_replies.size() == 0) begin
            note_mismatch("unexpected response beat, status", 32'd0, {30'd0, sts});
            return;
         end
         want = pending_replies.pop_front();
         if (sts !== want.status)
            note_mismatch("status", 32'(want.status), 32'(sts));
         if (data[31:0] !== want.start)
            note_mismatch("entry_start", want.start, data[31:0]);
         if (data[63:32] !== want.length)
            note_mismatch("entry_length", want.length, data[63:32]);
         if (data[79:64] !== want.flag)
            note_mismatch("entry_flag", 32'(want.flag), 32'(data[79:64]));
         if (data[84:80] !== want.count)
            note_mismatch("entry_count", 32'(want.count), 32'(data[84:80]));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [87:0]       req_tdata;
   logic [1:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [87:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   range_table_model model = new();
   bit               req_steady = 1'b0;
   bit               rsp_steady = 1'b0;

   address_range_carver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_address_range_carver: done, errors");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] wide_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 32'h0000_0000;
      if (r == 1)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // A value in [0, lim], biased toward both ends.
   function automatic logic [31:0] pick_within(logic [63:0] lim);
      int          r;
      logic [63:0] v;
      r = $urandom_range(0, 9);
      if (r < 2)
         return 32'd0;
      if (r < 4)
         return lim[31:0];
      if (r < 6) begin
         v = 64'($urandom_range(0, 15));
         return (v > lim) ? lim[31:0] : v[31:0];
      end
      v = {$urandom, $urandom} % (lim + 64'd1);
      return v[31:0];
   endfunction

   // Response side: hold-off stretches between runs of ready.
   initial begin
      int stall;
      int hold;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap(rsp_steady);
         hold  = $urandom_range(1, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.check_response(rsp_tuser, rsp_tdata);
   end

   // Drives one request beat and returns at the edge where it is accepted.
   task automatic send_request(cmd_type cmd, logic [31:0] b, logic [31:0] n,
                               logic [15:0] f, logic [3:0] idx);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'h0, idx, f, n, b};
      do @(posedge clock); while (!req_tready);
      model.accept_request(cmd, b, n, f, idx);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (model.pending_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register.
   task automatic csr_access(reg_type r, logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      model.write_reg(r, v);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== model.reg_value(r))
         model.note_mismatch("register read-back", model.reg_value(r), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] total, logic [15:0] mask, logic [15:0] idle);
      drain_results();
      csr_access(REG_TOTAL_SIZE, total);
      csr_access(REG_TYPE_MASK, {16'h0000, mask});
      csr_access(REG_IDLE_CODE, {16'h0000, idle});
      @(posedge clock);
   endtask

   // Mostly claims carved out of existing entries, so the table fills and sorts;
   // the rest are reads, inits, no-op beats and off-target claims.
   task automatic run_random(int n_items, bit pause_midway);
      cmd_type     cmd;
      logic [31:0] b;
      logic [31:0] n;
      logic [15:0] f;
      logic [3:0]  idx;
      entry_type   e;
      logic [31:0] off;
      int          pick;
      int          t;
      int          slot;
      for (int i = 0; i < n_items; i++) begin
         if (pause_midway && i == n_items / 2)
            drain_results();
         b    = wide_value();
         n    = wide_value();
         f    = 16'($urandom);
         idx  = 4'($urandom);
         pick = $urandom_range(0, 99);
         t    = (model.used >= MAX_RANGES - 1) ? 25 : 4;
         if (pick < t)
            cmd = CMD_INIT;
         else if (pick < t + 3)
            cmd = CMD_NONE;
         else if (pick < t + 33)
            cmd = CMD_READ;
         else
            cmd = CMD_CLAIM;
         if (cmd == CMD_READ && model.used > 0 && $urandom_range(0, 9) < 8)
            idx = 4'($urandom_range(0, model.used - 1));
         if (cmd == CMD_CLAIM && model.used > 0 && $urandom_range(0, 9) < 9) begin
            slot = $urandom_range(0, model.used - 1);
            if ($urandom_range(0, 4) != 0) begin
               for (int k = 0; k < model.used; k++) begin
                  if (model.is_idle(model.entries[(slot + k) % model.used])) begin
                     slot = (slot + k) % model.used;
                     break;
                  end
               end
            end
            e   = model.entries[slot];
            off = pick_within({32'd0, e.length});
            b   = e.start + off;
            n   = pick_within({32'd0, e.length - off});
            // Now and then ask for one byte more than picked, which may overrun the entry.
            if ($urandom_range(0, 9) == 0)
               n = n + 32'd1;
            if ($urandom_range(0, 2) == 0)
               f = (f & ~model.type_mask) | model.idle_code;
         end
         send_request(cmd, b, n, f, idx);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_INIT;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Reset register values: the table is empty until the first init.
      send_request(CMD_READ,  32'd0, 32'd0, 16'd0, 4'd0);
      send_request(CMD_CLAIM, 32'd0, 32'd0, 16'd0, 4'd0);
      send_request(CMD_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
      send_request(CMD_INIT,  32'd0, 32'd0, 16'd0, 4'd0);
      send_request(CMD_CLAIM, 32'd0, 32'd0, 16'h0001, 4'd0);
      send_request(CMD_READ,  32'd0, 32'd0, 16'd0, 4'd0);

      // Whole address space; claims at the very top and over idle-typed claims.
      configure(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
      send_request(CMD_INIT,  32'd0, 32'd0, 16'd0, 4'd0);
      send_request(CMD_CLAIM, 32'hFFFF_FFFE, 32'd1, 16'hFFFF, 4'd0);
      send_request(CMD_CLAIM, 32'd0, 32'hFFFF_FFFF, 16'h0000, 4'd0);
      send_request(CMD_CLAIM, 32'hFFFF_FFFF, 32'd1, 16'h0010, 4'd0);
      send_request(CMD_CLAIM, 32'h0000_1000, 32'h100, 16'h0000, 4'd0);
      send_request(CMD_CLAIM, 32'h0000_1000, 32'h100, 16'hABCD, 4'd0);
      send_request(CMD_READ,  32'd0, 32'd0, 16'd0, 4'hF);
      send_request(CMD_READ,  32'd0, 32'd0, 16'd0, 4'd1);
      // Keep carving until the table reports full.
      for (int k = 0; k < 7; k++)
         send_request(CMD_CLAIM, 32'h2000_0000 + k * 32'h1000, 32'h10, 16'(k), 4'd0);
      send_request(CMD_READ,  32'd0, 32'd0, 16'd0, 4'hE);
      send_request(CMD_NONE,  32'd0, 32'd0, 16'd0, 4'd0);

      configure(32'h0001_0000, 16'h000F, 16'h0000);
      run_random(250, 1'b1);
      configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      run_random(250, 1'b0);
      // An empty mask makes every entry idle, claimed or not.
      configure(32'h0000_1000, 16'h0000, 16'h0000);
      run_random(150, 1'b0);
      // Idle code has bits outside the mask, so nothing can be claimed.
      configure(32'h0000_0000, 16'h00F0, 16'h0105);
      run_random(60, 1'b0);
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      configure(wide_value(), 16'h0F0F, 16'h0A05);
      run_random(320, 1'b0);
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      configure(32'hFFFF_FFFF, 16'h8001, 16'h8000);
      run_random(350, 1'b0);

      drain_results();
      repeat (100) @(posedge clock);
      if (model.mismatch_count == 0)
         $display("tb_address_range_carver: done, clean");
      else
         $display("tb_address_range_carver: done, errors");
      $finish;
   end

endmodule
